>>> rtl/ertt_pkg.sv
package ertt_pkg;

    // Field widths fixed by the item formats.
    localparam int TIME_W  = 40;
    localparam int SEQ_W   = 16;
    localparam int RTT_W   = 24;
    localparam int CNT_W   = 16;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 7;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [RTT_W-1:0]  t_rtt;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [SLOT_W-1:0] t_slot_num;

    // Result status codes.
    localparam t_status ST_SENT      = 3'd0;
    localparam t_status ST_SENT_FULL = 3'd1;
    localparam t_status ST_MATCHED   = 3'd2;
    localparam t_status ST_SHORT     = 3'd3;
    localparam t_status ST_FOREIGN   = 3'd4;
    localparam t_status ST_UNKNOWN   = 3'd5;

    // Reply screening constants.
    localparam logic [7:0]         ECHO_REPLY_TYPE = 8'd0;
    localparam logic signed [12:0] MIN_ECHO_BYTES  = 13'sd8;

    // Microsecond to millisecond conversion. Below the saturation limit the
    // elapsed time divided by 8 fits in DIV_W bits; the remaining division
    // by 125 is a multiplication by ceil(2^RECIP_SHIFT / 125), exact over
    // that whole range.
    localparam int            TICKS_PER_MS = 1000;
    localparam t_time         SAT_LIMIT_US = TIME_W'(TICKS_PER_MS) << RTT_W;
    localparam t_rtt          RTT_MAX      = '1;
    localparam int            PRE_SHIFT    = 3;
    localparam int            DIV_W        = 31;
    localparam int            RECIP_SHIFT  = 38;
    localparam int            PROD_W       = DIV_W + 32;
    localparam logic [31:0]   RECIP_125    = 32'd2199023256;

    typedef logic [PROD_W-1:0] t_prod;

    // One slot of the outstanding request table.
    typedef struct packed {
        logic  busy;
        t_seq  seq;
        t_time start_us;
    } t_slot_entry;

    // Result of the millisecond converter toward the sequencer.
    typedef struct packed {
        logic done;
        t_rtt rtt_ms;
    } t_conv_result;

endpackage

>>> rtl/ertt_slot_table.sv
module ertt_slot_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  ertt_pkg::t_slot_entry    i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output ertt_pkg::t_slot_entry    o_rdata
);

    ertt_pkg::t_slot_entry r_mem [DEPTH];
    ertt_pkg::t_slot_entry r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ertt_ms_conv.sv
module ertt_ms_conv (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  ertt_pkg::t_time        i_elapsed_us,
    output ertt_pkg::t_conv_result o_result
);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_SHIFT = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic                       r_done, n_done;
    ertt_pkg::t_time            r_val, n_val;
    ertt_pkg::t_prod            r_prod, n_prod;
    ertt_pkg::t_rtt             r_quo, n_quo;
    logic [ertt_pkg::DIV_W-1:0] scaled;

    // Dividing by 1000 is a shift by 3 followed by a division by 125, done as
    // a multiplication by the scaled reciprocal of 125.
    assign scaled = r_val[ertt_pkg::PRE_SHIFT +: ertt_pkg::DIV_W];

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_val   = r_val;
        n_prod  = r_prod;
        n_quo   = r_quo;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_val   = i_elapsed_us;
                    n_state = D_CHECK;
                end
            end
            D_CHECK: begin
                if (r_val >= ertt_pkg::SAT_LIMIT_US) begin
                    n_quo   = ertt_pkg::RTT_MAX;
                    n_done  = 1'b1;
                    n_state = D_IDLE;
                end else begin
                    n_prod  = ertt_pkg::t_prod'(scaled)
                            * ertt_pkg::t_prod'(ertt_pkg::RECIP_125);
                    n_state = D_SHIFT;
                end
            end
            D_SHIFT: begin
                n_quo   = r_prod[ertt_pkg::RECIP_SHIFT +: ertt_pkg::RTT_W];
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_val  <= n_val;
        r_prod <= n_prod;
        r_quo  <= n_quo;
    end

    assign o_result.done   = r_done;
    assign o_result.rtt_ms = r_quo;

endmodule

>>> rtl/echo_request_rtt_tracker.sv
// Echo request round-trip tracker. After reset the block sweeps its slot table
// clear, one slot per cycle, and takes no item until the sweep is done. For a
// send item the table is scanned for the lowest free slot at one read per
// cycle through its single read port. A reply that fails the length or
// identity checks finishes without a scan; an accepted reply is scanned the
// same way for its sequence, and a match is followed by the microsecond to
// millisecond conversion by reciprocal multiplication, which skips the
// multiplication when the round trip saturates. One item is in work at a time;
// a finished result waits in the output register while the next item is taken.
// The identifier register is written through i_cfg_we.
module echo_request_rtt_tracker #(
    parameter int SLOT_COUNT = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration.
    input  logic                      i_cfg_we,
    input  logic [15:0]               i_cfg_data,
    // Input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic [39:0]               i_now_us,
    input  logic [11:0]               i_packet_length,
    input  logic [3:0]                i_ip_header_words,
    input  logic [7:0]                i_message_type,
    input  logic [15:0]               i_reply_identifier,
    input  logic [15:0]               i_reply_sequence,
    // Output channel.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_status,
    output logic [15:0]               o_sequence_out,
    output logic [6:0]                o_slot_index,
    output logic [23:0]               o_rtt_ms,
    output logic [15:0]               o_sent_total,
    output logic [15:0]               o_received_total
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CONV  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [AW-1:0]           r_addr, n_addr;
    logic                    r_rd_vld;
    logic [AW-1:0]           r_rd_idx;
    logic                    r_is_reply, n_is_reply;
    ertt_pkg::t_time         r_now, n_now;
    ertt_pkg::t_seq          r_rseq, n_rseq;
    ertt_pkg::t_status       r_res_status, n_res_status;
    ertt_pkg::t_seq          r_res_seq, n_res_seq;
    logic [AW-1:0]           r_res_slot, n_res_slot;
    ertt_pkg::t_rtt          r_res_rtt, n_res_rtt;
    ertt_pkg::t_count        r_sent_cnt, n_sent_cnt;
    ertt_pkg::t_count        r_recv_cnt, n_recv_cnt;
    logic [15:0]             r_own_id;
    logic                    r_out_valid;
    ertt_pkg::t_status       r_out_status;
    ertt_pkg::t_seq          r_out_seq;
    ertt_pkg::t_slot_num     r_out_slot;
    ertt_pkg::t_rtt          r_out_rtt;
    ertt_pkg::t_count        r_out_sent;
    ertt_pkg::t_count        r_out_recv;

    logic                    in_acc;
    logic                    out_free;
    logic                    out_load;
    logic                    hit;
    logic                    is_short;
    logic                    is_foreign;
    logic signed [12:0]      payload_len;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    ertt_pkg::t_slot_entry   mem_wdata;
    ertt_pkg::t_slot_entry   rd;
    logic                    div_start;
    ertt_pkg::t_time         div_elapsed;
    ertt_pkg::t_conv_result  conv;

    // Slot table and millisecond converter.
    ertt_slot_table #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd)
    );

    ertt_ms_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (div_start),
        .i_elapsed_us (div_elapsed),
        .o_result     (conv)
    );

    // Handshake terms.
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_DONE) && out_free;

    // Reply screening on the incoming item.
    assign payload_len = $signed({1'b0, i_packet_length})
                       - $signed({7'b0, i_ip_header_words, 2'b00});
    assign is_short    = (payload_len < ertt_pkg::MIN_ECHO_BYTES);
    assign is_foreign  = (i_message_type != ertt_pkg::ECHO_REPLY_TYPE)
                      || (i_reply_identifier != r_own_id);

    // Scan match: a free slot for a send, an equal sequence for a reply.
    assign hit         = r_is_reply ? (rd.seq == r_rseq) : !rd.busy;
    assign div_elapsed = r_now - rd.start_us;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_addr       = r_addr;
        n_is_reply   = r_is_reply;
        n_now        = r_now;
        n_rseq       = r_rseq;
        n_res_status = r_res_status;
        n_res_seq    = r_res_seq;
        n_res_slot   = r_res_slot;
        n_res_rtt    = r_res_rtt;
        n_sent_cnt   = r_sent_cnt;
        n_recv_cnt   = r_recv_cnt;
        mem_we       = 1'b0;
        mem_waddr    = r_rd_idx;
        mem_wdata    = '0;
        div_start    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                if (r_clr_addr == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                n_addr = '0;
                if (in_acc) begin
                    n_is_reply = i_action;
                    n_now      = i_now_us;
                    n_rseq     = i_reply_sequence;
                    n_res_seq  = '0;
                    n_res_slot = '0;
                    n_res_rtt  = '0;
                    if (!i_action) begin
                        n_res_seq  = r_sent_cnt;
                        n_sent_cnt = r_sent_cnt + 1'b1;
                        n_state    = S_SCAN;
                    end else if (is_short) begin
                        n_res_status = ertt_pkg::ST_SHORT;
                        n_state      = S_DONE;
                    end else if (is_foreign) begin
                        n_res_status = ertt_pkg::ST_FOREIGN;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_addr = (r_addr == LAST) ? r_addr : r_addr + 1'b1;
                if (r_rd_vld && hit) begin
                    mem_we     = 1'b1;
                    n_res_slot = r_rd_idx;
                    if (r_is_reply) begin
                        mem_wdata.busy     = 1'b0;
                        mem_wdata.seq      = rd.seq;
                        mem_wdata.start_us = rd.start_us;
                        n_res_status       = ertt_pkg::ST_MATCHED;
                        n_res_seq          = r_rseq;
                        div_start          = 1'b1;
                        n_state            = S_CONV;
                    end else begin
                        mem_wdata.busy     = 1'b1;
                        mem_wdata.seq      = r_res_seq;
                        mem_wdata.start_us = r_now;
                        n_res_status       = ertt_pkg::ST_SENT;
                        n_state            = S_DONE;
                    end
                end else if (r_rd_vld && (r_rd_idx == LAST)) begin
                    n_res_status = r_is_reply ? ertt_pkg::ST_UNKNOWN
                                              : ertt_pkg::ST_SENT_FULL;
                    n_state      = S_DONE;
                end
            end
            S_CONV: begin
                if (conv.done) begin
                    n_res_rtt = conv.rtt_ms;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    if (r_res_status == ertt_pkg::ST_MATCHED) begin
                        n_recv_cnt = r_recv_cnt + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_sent_cnt <= '0;
            r_recv_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_vld   <= (r_state == S_SCAN);
            r_sent_cnt <= n_sent_cnt;
            r_recv_cnt <= n_recv_cnt;
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_rd_idx     <= r_addr;
        r_is_reply   <= n_is_reply;
        r_now        <= n_now;
        r_rseq       <= n_rseq;
        r_res_status <= n_res_status;
        r_res_seq    <= n_res_seq;
        r_res_slot   <= n_res_slot;
        r_res_rtt    <= n_res_rtt;
    end

    // Identifier register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_we) begin
            r_own_id <= i_cfg_data;
        end
    end

    // Output register holds a finished item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_seq    <= r_res_seq;
            r_out_slot   <= ertt_pkg::t_slot_num'(r_res_slot);
            r_out_rtt    <= r_res_rtt;
            r_out_sent   <= r_sent_cnt;
            r_out_recv   <= n_recv_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_sequence_out   = r_out_seq;
    assign o_slot_index     = r_out_slot;
    assign o_rtt_ms         = r_out_rtt;
    assign o_sent_total     = r_out_sent;
    assign o_received_total = r_out_recv;

    // The block is busy right after taking an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input accepted while a previous item was still in work");

    // The converter only reports while the sequencer waits for it.
    a_conv_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv.done |-> (r_state == S_CONV))
        else $error("conversion finished outside the wait state");

    // The received count moves only with a matched result.
    a_recv_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_recv_cnt != $past(r_recv_cnt))
            |-> (r_out_valid && (r_out_status == ertt_pkg::ST_MATCHED)))
        else $error("received count changed without a matched reply");

endmodule
